// ===== design/aco_pkg.sv =====
`default_nettype none
package aco_pkg;

  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [24:0] KLOG_Q28 = 25'd29613209;
  localparam logic [31:0] Q30_ONE  = 32'd1073741824;

  localparam logic [1:0] REG_FREQ_MODE  = 2'd0;
  localparam logic [1:0] REG_FIXED_FREQ = 2'd1;
  localparam logic [1:0] REG_AMP        = 2'd2;
  localparam logic [1:0] REG_OFFSET     = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_Y,
    ST_TH,
    ST_U,
    ST_HMUL,
    ST_HREC,
    ST_HUPD,
    ST_LGY,
    ST_LGYW,
    ST_LGR,
    ST_LGRW,
    ST_DMUL,
    ST_DSTART,
    ST_DWAIT,
    ST_SCALE,
    ST_ROUND
  } top_state_e;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQ
  } lg_state_e;

  // Horner denominators 2k(2k+1) as reciprocals: floor(x/d) = (x*m) >> s for x below 2^32
  function automatic logic [32:0] horner_magic(input logic [2:0] k);
    logic [32:0] m;
    case (k)
      3'd7:    m = 33'd5235769657;
      3'd6:    m = 33'd7048151461;
      3'd5:    m = 33'd4997780127;
      3'd4:    m = 33'd7635497416;
      3'd3:    m = 33'd6544712071;
      3'd2:    m = 33'd6871947674;
      3'd1:    m = 33'd5726623062;
      default: m = 33'd0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] horner_shift(input logic [2:0] k);
    logic [5:0] s;
    case (k)
      3'd7:    s = 6'd40;
      3'd6:    s = 6'd40;
      3'd5:    s = 6'd39;
      3'd4:    s = 6'd39;
      3'd3:    s = 6'd38;
      3'd2:    s = 6'd37;
      3'd1:    s = 6'd35;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== design/averaged_cotangent_oscillator.sv =====
// Averaged cotangent oscillator. Each input transfer is one sample tick with a frequency
// (fraction of a cycle per sample); the result is one Q16.16 sample. Configuration writes:
// index 0 freq_mode, 1 fixed_freq, 2 amp, 3 offset; the port is always ready. One item
// runs through a sequencer that drives one shared multiplier, a radix-2 divider and a
// bit-serial log2 unit; the Horner divides by constants are reciprocal multiplies on the
// shared multiplier. A silent tick (zero frequency) goes from the check straight to the
// rounding, a tick at phase zero or wrapping to zero also passes the scaling, and a full
// tick runs fourteen Horner steps, four logarithms and one final divide. The input is
// not ready while an item is in work; the finished sample waits in an output register.
`default_nettype none
module averaged_cotangent_oscillator #(
  parameter int PHASE_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [23:0] freq_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [31:0] sample_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  import aco_pkg::*;

  localparam int PB  = PHASE_BITS;
  localparam int SHL = (PB >= 24) ? PB - 24 : 0;
  localparam int SHR = (PB < 24) ? 24 - PB : 0;
  localparam int VW  = FRAC_BITS + 8;
  localparam int SH  = 58 - PB - FRAC_BITS;
  localparam logic [63:0] VLIM = 64'd1 << (FRAC_BITS + 7);
  localparam logic [63:0] VMAX64 = VLIM - 64'd1;
  localparam logic signed [VW-1:0] VMAX = VW'(VMAX64);
  localparam logic signed [VW-1:0] VMIN = -VW'(VLIM);
  localparam logic signed [69:0] S_MAX = 70'sd2147483647;
  localparam logic signed [69:0] S_MIN = -70'sd2147483648;

  function automatic logic [PB-1:0] y_of(input logic [PB-1:0] x);
    logic [PB:0] full;
    logic [PB:0] r;
    full = (PB+1)'(1) << PB;
    r    = ({1'b0, x} <= (full >> 1)) ? {1'b0, x} : full - {1'b0, x};
    return r[PB-1:0];
  endfunction

  top_state_e state_q, state_d;

  logic             mode_q;
  logic [23:0]      fixed_q, amp_q, offset_q;
  logic [PB-1:0]    phase_q, phase_d;
  logic [PB-1:0]    fq_q, fq_d;
  logic [PB-1:0]    nxt_q, nxt_d;
  logic [PB-1:0]    y_q, y_d;
  logic             sel_q, sel_d;
  logic             zero_q, zero_d;
  logic [31:0]      u_q, u_d;
  logic [31:0]      r_q, r_d;
  logic [2:0]       kk_q, kk_d;
  logic [36:0]      la_q, la_d;
  logic [36:0]      acc_q, acc_d;
  logic [36:0]      mag_q, mag_d;
  logic signed [VW-1:0] v_q, v_d;
  logic signed [69:0] prod_q;
  logic             ovld_q, ovld_d;
  logic signed [31:0] out_q, out_d;

  logic [PB-1:0]      nxt_sum;
  logic signed [36:0] mul_a;
  logic signed [32:0] mul_b;
  logic [55:0]        conv;
  logic [69:0]        hq;
  logic               div_start, div_done;
  logic [63:0]        div_dvd, div_quo;
  logic [31:0]        div_dsr;
  logic               lg_start, lg_done;
  logic [31:0]        lg_n;
  logic [34:0]        lg_res;
  logic [36:0]        total;
  logic signed [37:0] dd;
  logic [63:0]        qv;
  logic signed [69:0] s_sum;
  logic               out_free;

  aco_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dsr),
    .done_o    (div_done),
    .quo_o     (div_quo)
  );

  aco_lg u_lg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(lg_start),
    .n_i    (lg_n),
    .done_o (lg_done),
    .res_o  (lg_res)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovld_q;
  assign sample_o    = out_q;
  assign out_free    = !ovld_q || out_ready_i;
  assign nxt_sum     = phase_q + fq_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (fq_q == '0) state_d = ST_ROUND;
        else if (phase_q == '0 || nxt_sum == '0) state_d = ST_SCALE;
        else state_d = ST_Y;
      end
      ST_Y:      state_d = ST_TH;
      ST_TH:     state_d = ST_U;
      ST_U:      state_d = ST_HMUL;
      ST_HMUL:   state_d = ST_HREC;
      ST_HREC:   state_d = ST_HUPD;
      ST_HUPD:   state_d = (kk_q == 3'd1) ? ST_LGY : ST_HMUL;
      ST_LGY:    state_d = ST_LGYW;
      ST_LGYW:   if (lg_done) state_d = ST_LGR;
      ST_LGR:    state_d = ST_LGRW;
      ST_LGRW:   if (lg_done) state_d = sel_q ? ST_DMUL : ST_Y;
      ST_DMUL:   state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT:  if (div_done) state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_ROUND;
      ST_ROUND:  if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    fq_d      = fq_q;
    nxt_d     = nxt_q;
    y_d       = y_q;
    sel_d     = sel_q;
    zero_d    = zero_q;
    u_d       = u_q;
    r_d       = r_q;
    kk_d      = kk_q;
    la_d      = la_q;
    acc_d     = acc_q;
    mag_d     = mag_q;
    v_d       = v_q;
    out_d     = out_q;
    ovld_d    = ovld_q && !out_ready_i;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = prod_q[63:0];
    div_dsr   = 32'(fq_q);
    lg_start  = 1'b0;
    lg_n      = 32'(y_q);
    conv      = (56'(mode_q ? fixed_q : freq_i) << SHL) >> SHR;
    hq        = $unsigned(prod_q) >> horner_shift(kk_q);
    total     = acc_q + 37'(lg_res);
    dd        = $signed({1'b0, la_q}) - $signed({1'b0, total});
    qv        = div_quo >> SH;
    s_sum     = (prod_q >>> FRAC_BITS) + 70'(signed'(offset_q));
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) fq_d = conv[PB-1:0];
      end
      ST_CHECK: begin
        nxt_d  = nxt_sum;
        zero_d = (fq_q == '0);
        sel_d  = 1'b0;
        y_d    = y_of(nxt_sum);
        if (phase_q == '0) v_d = VMAX;
        else v_d = VMIN;
      end
      ST_Y: begin
        mul_a = 37'(y_q);
        mul_b = 33'(PI_Q30);
      end
      ST_TH: begin
        mul_a = 37'(prod_q[PB+30:PB]);
        mul_b = 33'(prod_q[PB+30:PB]);
      end
      ST_U: begin
        u_d  = prod_q[61:30];
        r_d  = Q30_ONE;
        kk_d = 3'd7;
      end
      ST_HMUL: begin
        mul_a = 37'(u_q);
        mul_b = 33'(r_q);
      end
      ST_HREC: begin
        mul_a = 37'(horner_magic(kk_q));
        mul_b = 33'(prod_q[61:30]);
      end
      ST_HUPD: begin
        r_d  = Q30_ONE - hq[31:0];
        kk_d = kk_q - 3'd1;
      end
      ST_LGY: lg_start = 1'b1;
      ST_LGYW: if (lg_done) acc_d = 37'(lg_res);
      ST_LGR: begin
        lg_start = 1'b1;
        lg_n     = r_q;
      end
      ST_LGRW: begin
        if (lg_done) begin
          if (!sel_q) begin
            la_d  = total;
            sel_d = 1'b1;
            y_d   = y_of(phase_q);
          end else begin
            mag_d  = dd[37] ? 37'(-dd) : 37'(dd);
            zero_d = dd[37];
          end
        end
      end
      ST_DMUL: begin
        mul_a = $signed(mag_q);
        mul_b = 33'(KLOG_Q28);
      end
      ST_DSTART: div_start = 1'b1;
      ST_DWAIT: begin
        if (div_done) begin
          if (!zero_q) v_d = (qv > VMAX64) ? VMAX : VW'(qv);
          else v_d = (qv > VLIM) ? VMIN : -VW'(qv);
          zero_d = 1'b0;
        end
      end
      ST_SCALE: begin
        mul_a = 37'(v_q);
        mul_b = 33'(signed'(amp_q));
      end
      ST_ROUND: begin
        mul_a = 37'(v_q);
        mul_b = 33'(signed'(amp_q));
        if (out_free) begin
          ovld_d = 1'b1;
          if (zero_q) begin
            out_d   = 32'(signed'(offset_q));
            phase_d = '0;
          end else begin
            phase_d = nxt_q;
            if (s_sum > S_MAX) out_d = 32'(S_MAX);
            else if (s_sum < S_MIN) out_d = 32'(S_MIN);
            else out_d = s_sum[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= 1'b0;
      fixed_q  <= '0;
      amp_q    <= 24'd65536;
      offset_q <= '0;
      phase_q  <= '0;
      ovld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      ovld_q  <= ovld_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_FREQ_MODE:  mode_q   <= cfg_data_i[0];
          REG_FIXED_FREQ: fixed_q  <= cfg_data_i;
          REG_AMP:        amp_q    <= cfg_data_i;
          REG_OFFSET:     offset_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fq_q   <= fq_d;
    nxt_q  <= nxt_d;
    y_q    <= y_d;
    sel_q  <= sel_d;
    zero_q <= zero_d;
    u_q    <= u_d;
    r_q    <= r_d;
    kk_q   <= kk_d;
    la_q   <= la_d;
    acc_q  <= acc_d;
    mag_q  <= mag_d;
    v_q    <= v_d;
    out_q  <= out_d;
    prod_q <= 70'(mul_a) * 70'(mul_b);
  end
endmodule
`default_nettype wire

// ===== design/aco_div.sv =====
`default_nettype none
module aco_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] dvd_q, dvd_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        bit_ok;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[63]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    bit_ok  = (rem_sh >= {1'b0, dsr_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[62:0], bit_ok};
      rem_d = bit_ok ? rem_sub[31:0] : rem_sh[31:0];
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q;
endmodule
`default_nettype wire

// ===== design/aco_lg.sv =====
`default_nettype none
module aco_lg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] n_i,
  output logic             done_o,
  output logic [34:0]      res_o
);
  import aco_pkg::*;

  lg_state_e   state_q, state_d;
  logic        done_q, done_d;
  logic [31:0] m_q, m_d;
  logic [4:0]  k_q, k_d;
  logic [4:0]  i_q, i_d;
  logic [29:0] frac_q, frac_d;
  logic [61:0] sq;
  logic [31:0] sh;

  always_comb begin
    state_d = state_q;
    case (state_q)
      LG_IDLE: if (start_i) state_d = LG_NORM;
      LG_NORM: if (m_q[31]) state_d = LG_SQ;
      LG_SQ:   if (i_q == 5'd0) state_d = LG_IDLE;
      default: state_d = LG_IDLE;
    endcase
  end

  always_comb begin
    sq     = 62'(m_q[30:0]) * 62'(m_q[30:0]);
    sh     = sq[61:30];
    done_d = 1'b0;
    m_d    = m_q;
    k_d    = k_q;
    i_d    = i_q;
    frac_d = frac_q;
    case (state_q)
      LG_IDLE: begin
        if (start_i) begin
          m_d    = n_i;
          k_d    = 5'd31;
          frac_d = '0;
        end
      end
      LG_NORM: begin
        if (m_q[31]) begin
          m_d = {1'b0, m_q[31:1]};
          i_d = 5'd29;
        end else begin
          m_d = {m_q[30:0], 1'b0};
          k_d = k_q - 5'd1;
        end
      end
      LG_SQ: begin
        if (sh[31]) begin
          m_d         = {1'b0, sh[31:1]};
          frac_d[i_q] = 1'b1;
        end else begin
          m_d = sh;
        end
        if (i_q == 5'd0) done_d = 1'b1;
        else i_d = i_q - 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    k_q    <= k_d;
    i_q    <= i_d;
    frac_q <= frac_d;
  end

  assign done_o = done_q;
  assign res_o  = {k_q, frac_q};
endmodule
`default_nettype wire

// ===== tb/tb_averaged_cotangent_oscillator.sv =====
`timescale 1ns / 100ps
module tb_averaged_cotangent_oscillator;
  import aco_pkg::*;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned PI_FIX  = 64'd3373259426;
  localparam longint unsigned LN2_2PI = 64'd29613209;
  localparam longint          V_MAX   = (64'sd1 <<< 23) - 1;
  localparam longint          V_MIN   = -(64'sd1 <<< 23);
  localparam int              STALL_LIMIT = 20000;

  class sample_scoreboard;
    bit               mode;
    bit [23:0]        fixed_freq;
    bit [23:0]        amp;
    bit [23:0]        offset;
    bit [23:0]        phase;
    int               errors;
    logic signed [31:0] pending[$];

    function new();
      mode = 0;
      fixed_freq = 0;
      amp = 24'd65536;
      offset = 0;
      phase = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        REG_FREQ_MODE:  mode = data[0];
        REG_FIXED_FREQ: fixed_freq = data;
        REG_AMP:        amp = data;
        REG_OFFSET:     offset = data;
        default: ;
      endcase
    endfunction

    function longint log2_fix(longint unsigned n);
      int msb;
      longint unsigned m;
      longint frac;
      msb = 63;
      frac = 0;
      if (n == 0) return 0;
      while (n[msb] == 1'b0) msb--;
      m = (msb >= 30) ? (n >> (msb - 30)) : (n << (30 - msb));
      for (int i = 29; i >= 0; i--) begin
        m = (m * m) >> 30;
        if (m >= (ONE_Q30 << 1)) begin
          m = m >> 1;
          frac = frac | (64'sd1 <<< i);
        end
      end
      return (longint'(msb) <<< 30) + frac;
    endfunction

    function longint log_sine(longint unsigned x);
      longint unsigned y, th, u, r;
      y = (x <= 64'h800000) ? x : 64'h1000000 - x;
      th = (y * PI_FIX) >> 24;
      u = (th * th) >> 30;
      r = ONE_Q30;
      for (int k = 7; k >= 1; k--)
        r = ONE_Q30 - ((u * r) >> 30) / longint'(2 * k * (2 * k + 1));
      return log2_fix(y) + log2_fix(r);
    endfunction

    function void note_input(logic [23:0] freq);
      bit [23:0] f, nxt;
      longint v, d, p, s;
      longint unsigned mag, q;
      f = mode ? fixed_freq : freq;
      if (f == 0) begin
        phase = 0;
        s = longint'($signed(offset));
      end else begin
        nxt = phase + f;
        if (phase == 0) v = V_MAX;
        else if (nxt == 0) v = V_MIN;
        else begin
          d = log_sine(nxt) - log_sine(phase);
          mag = (d < 0) ? longint'(-d) : d;
          q = ((mag * LN2_2PI) / f) >> 18;
          if (d >= 0) v = (q > V_MAX) ? V_MAX : longint'(q);
          else v = (q > (64'd1 << 23)) ? V_MIN : -longint'(q);
        end
        phase = nxt;
        p = v * longint'($signed(amp));
        s = (p >>> 16) + longint'($signed(offset));
      end
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      pending.push_back(s[31:0]);
    endfunction

    function void check(logic signed [31:0] got);
      logic signed [31:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected sample %0d", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: sample mismatch expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic [23:0] freq_i;
  logic out_valid_o, out_ready_i;
  logic signed [31:0] sample_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [23:0] cfg_data_i;

  sample_scoreboard sb = new();
  int send_idle, recv_stall, idle_cycles, hold_cnt;
  bit hold_req;

  averaged_cotangent_oscillator dut (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check(sample_o);
    if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_freq(logic [23:0] f);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    freq_i <= f;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(f);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_freq();
    case ($urandom_range(9))
      0:       return 24'd0;
      1:       return 24'($urandom_range(255));
      2:       return 24'hFFFFFF - 24'($urandom_range(255));
      3:       return 24'h800000;
      4, 5:    return 24'($urandom_range(24'h00FFFF));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    rst_ni = 0;
    in_valid_i = 0;
    freq_i = 0;
    out_ready_i = 0;
    cfg_valid_i = 0;
    cfg_index_i = REG_FREQ_MODE;
    cfg_data_i = 0;
    send_idle = 0;
    recv_stall = 0;
    idle_cycles = 0;
    hold_cnt = 0;
    hold_req = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_freq(24'd0);
    send_freq(24'h800000);
    send_freq(24'h800000);
    send_freq(24'd1);
    send_freq(24'hFFFFFF);
    send_freq(24'h555555);
    send_freq(24'hAAAAAA);
    send_freq(24'd0);
    send_freq(24'h400000);
    send_freq(24'h400000);
    send_freq(24'h400000);
    send_freq(24'h400000);
    drain();
    cfg_write(REG_AMP, 24'h800000);
    cfg_write(REG_OFFSET, 24'h7FFFFF);
    send_freq(24'h000123);
    send_freq(24'h000001);
    send_freq(24'd0);
    drain();
    cfg_write(REG_AMP, 24'h7FFFFF);
    cfg_write(REG_OFFSET, 24'h800000);
    cfg_write(REG_FIXED_FREQ, 24'hFFFFFF);
    cfg_write(REG_FREQ_MODE, 24'd1);
    send_freq(24'd0);
    send_freq(24'h123456);
    send_freq(24'hFFFFFF);
    drain();
    cfg_write(REG_FIXED_FREQ, 24'd0);
    send_freq(24'h123456);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_FREQ_MODE, 24'(ph % 4 == 3));
      cfg_write(REG_FIXED_FREQ, (ph == 7) ? 24'hFFFFFF : 24'($urandom));
      cfg_write(REG_AMP, (ph == 0) ? 24'd65536 : 24'($urandom));
      cfg_write(REG_OFFSET, (ph == 5) ? 24'd0 : 24'($urandom));
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 83; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 83; end
        default: begin send_idle = 34; recv_stall = 34; end
      endcase
      if (ph == 4) hold_req = 1;
      for (int i = 0; i < 160; i++) send_freq(rand_freq());
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
